>>> rtl/fpc_pkg.sv
// shared types and constants of the polynomial colorizer
package fpc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RANGE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCHEME_SELECT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 4'd7;

  // field widths
  localparam int RANGE_W  = 24;
  localparam int GAIN_W   = 16;
  localparam int SCHEME_W = 2;
  localparam int STRIDE_W = 16;
  localparam int BPP_W    = 7;
  localparam int ADDR_W   = 32;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int OUT_W    = ADDR_W + COLOR_W;

  // fixed point
  localparam int N_W  = 17;   // Q1.16 including the value one
  localparam int P_W  = 40;   // polynomial kept with 40 fraction bits
  localparam int F_W  = P_W + GAIN_W;
  localparam logic [N_W-1:0]    ONE_Q16  = 17'h10000;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // scheme codes
  localparam logic [SCHEME_W-1:0] SCHEME_RED   = 2'd0;
  localparam logic [SCHEME_W-1:0] SCHEME_GREEN = 2'd1;
  localparam logic [SCHEME_W-1:0] SCHEME_BLUE  = 2'd2;

  // pipeline depth
  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [RANGE_W-1:0]  color_range;
    logic [GAIN_W-1:0]   red_gain;
    logic [GAIN_W-1:0]   green_gain;
    logic [GAIN_W-1:0]   blue_gain;
    logic [SCHEME_W-1:0] scheme_select;
    logic [STRIDE_W-1:0] row_stride;
    logic [BPP_W-1:0]    pixel_bits;
    logic [ADDR_W-1:0]   frame_base;
  } cfg_t;

endpackage

>>> rtl/fpc_cfg_regs.sv
// configuration register file of the polynomial colorizer
module fpc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0] wr_data,
  output fpc_pkg::cfg_t                cfg
);
  import fpc_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_range   <= 24'd4096;
      cfg.red_gain      <= 16'd1024;
      cfg.green_gain    <= 16'd1024;
      cfg.blue_gain     <= 16'd1024;
      cfg.scheme_select <= SCHEME_RED;
      cfg.row_stride    <= 16'd4096;
      cfg.pixel_bits    <= 7'd32;
      cfg.frame_base    <= 32'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_COLOR_RANGE:   cfg.color_range   <= wr_data[RANGE_W-1:0];
        REG_RED_GAIN:      cfg.red_gain      <= wr_data[GAIN_W-1:0];
        REG_GREEN_GAIN:    cfg.green_gain    <= wr_data[GAIN_W-1:0];
        REG_BLUE_GAIN:     cfg.blue_gain     <= wr_data[GAIN_W-1:0];
        REG_SCHEME_SELECT: cfg.scheme_select <= wr_data[SCHEME_W-1:0];
        REG_ROW_STRIDE:    cfg.row_stride    <= wr_data[STRIDE_W-1:0];
        REG_PIXEL_BITS:    cfg.pixel_bits    <= wr_data[BPP_W-1:0];
        REG_FRAME_BASE:    cfg.frame_base    <= wr_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/fpc_color_pipe.sv
// color datapath: iteration scale, clamp, polynomials, gains, saturation
module fpc_color_pipe #(
  parameter int ITER_BITS = 12
) (
  input  logic                            clk,
  input  logic [fpc_pkg::NUM_STAGES-1:0]  en,
  input  fpc_pkg::cfg_t                   cfg,
  input  logic [ITER_BITS-1:0]            iter_count,
  output logic [fpc_pkg::COLOR_W-1:0]     pixel_color
);
  import fpc_pkg::*;

  localparam int T_W = ITER_BITS + RANGE_W;

  // truncate to integer and saturate: (f * 255) >> 50
  function automatic logic [CHAN_W-1:0] sat_chan(input logic [F_W-1:0] f);
    logic [63:0] w;
    w = {f, 8'b0} - {8'b0, f};
    if (|w[63:58]) return CHAN_MAX;
    return w[57:50];
  endfunction

  logic [T_W-1:0]   t;
  logic [N_W-1:0]   n;
  logic [N_W-1:0]   m;
  logic [N_W-1:0]   n_next;
  logic [32:0]      m2;
  logic [30:0]      mn;
  logic [32:0]      n2;
  logic [63:0]      p31_full;
  logic [63:0]      p22_full;
  logic [63:0]      p13_full;
  logic [P_W-1:0]   p31;
  logic [P_W-1:0]   p22;
  logic [P_W-1:0]   p13;
  logic [P_W-1:0]   pr;
  logic [P_W-1:0]   pg;
  logic [P_W-1:0]   pb;
  logic [F_W-1:0]   fr;
  logic [F_W-1:0]   fg;
  logic [F_W-1:0]   fb;

  // clamp of the scaled count to one
  always_comb begin
    if (t[T_W-1:8] > (T_W-8)'(ONE_Q16)) n_next = ONE_Q16;
    else n_next = t[8 +: N_W];
  end

  // exact fourth degree products
  assign p31_full = {31'b0, m2} * {33'b0, mn};
  assign p22_full = {33'b0, mn} * {33'b0, mn};
  assign p13_full = {33'b0, mn} * {31'b0, n2};

  // channel mapping of the scheme
  always_comb begin
    case (cfg.scheme_select)
      SCHEME_GREEN: begin
        pr = p22; pg = p31; pb = p13;
      end
      SCHEME_BLUE: begin
        pr = p13; pg = p22; pb = p31;
      end
      default: begin
        pr = p31; pg = p22; pb = p13;
      end
    endcase
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en[0]) t <= T_W'(iter_count) * T_W'(cfg.color_range);
    if (en[1]) begin
      n <= n_next;
      m <= ONE_Q16 - n_next;
    end
    if (en[2]) begin
      m2 <= 33'(m) * 33'(m);
      mn <= 31'(m) * 31'(n);
      n2 <= 33'(n) * 33'(n);
    end
    if (en[3]) begin
      p31 <= p31_full[63:24];
      p22 <= p22_full[63:24];
      p13 <= p13_full[63:24];
    end
    if (en[4]) begin
      fr <= F_W'(pr) * F_W'(cfg.red_gain);
      fg <= F_W'(pg) * F_W'(cfg.green_gain);
      fb <= F_W'(pb) * F_W'(cfg.blue_gain);
    end
    if (en[5]) pixel_color <= {sat_chan(fr), sat_chan(fg), sat_chan(fb)};
  end

endmodule

>>> rtl/fpc_addr_pipe.sv
// framebuffer address datapath, delayed to match the color latency
module fpc_addr_pipe #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic [fpc_pkg::NUM_STAGES-1:0]  en,
  input  fpc_pkg::cfg_t                   cfg,
  input  logic [COORD_BITS-1:0]           pos_x,
  input  logic [COORD_BITS-1:0]           pos_y,
  output logic [fpc_pkg::ADDR_W-1:0]      pixel_address
);
  import fpc_pkg::*;

  localparam int LAST  = NUM_STAGES - 1;
  localparam int YO_W  = COORD_BITS + STRIDE_W;
  localparam int XO_W  = COORD_BITS + 4;

  logic [YO_W-1:0]                y_off;
  logic [XO_W-1:0]                x_off;
  logic [ADDR_W-1:0]              addr_dly [1:LAST];

  assign pixel_address = addr_dly[LAST];

  // offsets, sum, then a delay line
  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_off <= YO_W'(pos_y) * YO_W'(cfg.row_stride);
      x_off <= XO_W'(pos_x) * XO_W'(cfg.pixel_bits[BPP_W-1:3]);
    end
    if (en[1]) addr_dly[1] <= cfg.frame_base + ADDR_W'(y_off) + ADDR_W'(x_off);
    for (int k = 2; k <= LAST; k++) begin
      if (en[k]) addr_dly[k] <= addr_dly[k-1];
    end
  end

endmodule

>>> rtl/fractal_polynomial_colorizer_core.sv
// top level of the polynomial escape-time colorizer
//
// Takes one pixel (iteration count, column, row) per clock and returns its
// packed 0xRRGGBB color and framebuffer byte address. Throughput is one pixel
// per cycle while the output is not stalled, in a six-stage pipeline whose
// depth is set by the chain of multipliers (count times range, squares and
// cross term, fourth degree products, gains, times 255). Each stage holds its
// own valid bit and takes new data when it is empty or its successor moves,
// so a stall on the output fills bubbles first and s_tready falls only when
// all six stages are full. Configuration is written through the cfg channel,
// which is always ready, and must only change while the pipeline is empty.
module fractal_polynomial_colorizer_core #(
  parameter int ITER_BITS  = 12,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // iter_count, pos_x, pos_y from bit 0 up, zero padded to bytes
  input  logic [((ITER_BITS+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_address, pixel_color from bit 0 up
  output logic [fpc_pkg::OUT_W-1:0]       m_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpc_pkg::*;

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] prev_vld;
  logic [NUM_STAGES:0]   rdy;
  logic [ADDR_W-1:0]     pixel_address;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  in_acc;
  logic                  out_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;

  fpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // per-stage ready chain
  assign prev_vld = {vld[NUM_STAGES-2:0], s_tvalid};
  always_comb begin
    rdy[NUM_STAGES] = m_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    en = rdy[NUM_STAGES-1:0] & prev_vld;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) vld[k] <= prev_vld[k];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {pixel_color, pixel_address};

  fpc_color_pipe #(
    .ITER_BITS (ITER_BITS)
  ) u_color (
    .clk         (clk),
    .en          (en),
    .cfg         (cfg),
    .iter_count  (s_tdata[ITER_BITS-1:0]),
    .pixel_color (pixel_color)
  );

  fpc_addr_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk           (clk),
    .en            (en),
    .cfg           (cfg),
    .pos_x         (s_tdata[ITER_BITS +: COORD_BITS]),
    .pos_y         (s_tdata[ITER_BITS+COORD_BITS +: COORD_BITS]),
    .pixel_address (pixel_address)
  );

`ifndef SYNTHESIS
  // a full pipeline with a stalled output takes no new pixel
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline full and stalled");

  // an accepted pixel lands in the first stage
  a_first_stage: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> vld[0])
    else $error("accepted pixel missing from first stage");

  // pixels in flight change only by transactions on the two sides
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(vld) ==
      $past($countones(vld)) + $past(int'(in_acc)) - $past(int'(out_acc)))
    else $error("pipeline occupancy lost or duplicated a pixel");
`endif

endmodule

>>> tb/tb_fractal_polynomial_colorizer_core.sv
// self-checking testbench of the polynomial escape-time colorizer core
module tb_fractal_polynomial_colorizer_core;
  import fpc_pkg::*;

  localparam int ITER_BITS      = 12;
  localparam int COORD_BITS     = 12;
  localparam int S_W            = ((ITER_BITS + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int NUM_REGS       = 8;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * NUM_STAGES;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_PIXELS   = 70;
  localparam logic [SCHEME_W-1:0] SCHEME_UNUSED = 2'd3;
  localparam logic [63:0] ONE_FIX = 64'd65536;

  // result fields, pixel_address in the low bits
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  address;
  } pixel_out_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // pixels waiting to be sent and colors/addresses waiting to come back
  logic [S_W-1:0] pixel_q [$];
  pixel_out_t     pixel_expect_q [$];

  cfg_t shadow_cfg;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count    = 0;
  int   pixels_checked = 0;
  int   reg_writes    = 0;
  int   settings_run  = 0;
  int   idle_cycles   = 0;

  always #5 clk = ~clk;

  fractal_polynomial_colorizer_core #(
    .ITER_BITS (ITER_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // iter_count, pos_x, pos_y from bit 0 up
  function automatic logic [S_W-1:0] pack_pixel(input logic [ITER_BITS-1:0] iter,
                                                input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y);
    return {{(S_W - ITER_BITS - 2 * COORD_BITS){1'b0}}, y, x, iter};
  endfunction

  // gain * (1-n)^a * n^b * 255, truncated and saturated
  function automatic logic [CHAN_W-1:0] bernstein_channel(input logic [63:0] m,
                                                          input logic [63:0] n,
                                                          input int a, input int b,
                                                          input logic [GAIN_W-1:0] gain);
    logic [63:0] prod;
    logic [63:0] level;
    prod = 64'd1;
    for (int k = 0; k < a; k++) prod = prod * m;
    for (int k = 0; k < b; k++) prod = prod * n;
    level = ((prod >> 24) * {48'd0, gain} * 64'd255) >> 50;
    if (level > 64'd255) return CHAN_MAX;
    return level[CHAN_W-1:0];
  endfunction

  // color and framebuffer address of one pixel under the current settings
  function automatic pixel_out_t predict_pixel(input logic [S_W-1:0] word);
    logic [ITER_BITS-1:0]  iter;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [63:0]           n;
    logic [63:0]           m;
    logic [CHAN_W-1:0]     red, green, blue;
    pixel_out_t            res;
    iter = word[ITER_BITS-1:0];
    x    = word[ITER_BITS +: COORD_BITS];
    y    = word[ITER_BITS + COORD_BITS +: COORD_BITS];
    n = (64'(iter) * 64'(shadow_cfg.color_range)) >> 8;
    if (n > ONE_FIX) n = ONE_FIX;
    m = ONE_FIX - n;
    case (shadow_cfg.scheme_select)
      SCHEME_GREEN: begin
        red   = bernstein_channel(m, n, 2, 2, shadow_cfg.red_gain);
        green = bernstein_channel(m, n, 3, 1, shadow_cfg.green_gain);
        blue  = bernstein_channel(m, n, 1, 3, shadow_cfg.blue_gain);
      end
      SCHEME_BLUE: begin
        red   = bernstein_channel(m, n, 1, 3, shadow_cfg.red_gain);
        green = bernstein_channel(m, n, 2, 2, shadow_cfg.green_gain);
        blue  = bernstein_channel(m, n, 3, 1, shadow_cfg.blue_gain);
      end
      default: begin
        // red scheme, and the unused code behaves the same
        red   = bernstein_channel(m, n, 3, 1, shadow_cfg.red_gain);
        green = bernstein_channel(m, n, 2, 2, shadow_cfg.green_gain);
        blue  = bernstein_channel(m, n, 1, 3, shadow_cfg.blue_gain);
      end
    endcase
    res.color   = {red, green, blue};
    res.address = shadow_cfg.frame_base
                + 32'(y) * 32'(shadow_cfg.row_stride)
                + 32'(x) * 32'(shadow_cfg.pixel_bits / 8);
    return res;
  endfunction

  // one register write transaction, shadow copy follows at the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      REG_COLOR_RANGE:   shadow_cfg.color_range   = data[RANGE_W-1:0];
      REG_RED_GAIN:      shadow_cfg.red_gain      = data[GAIN_W-1:0];
      REG_GREEN_GAIN:    shadow_cfg.green_gain    = data[GAIN_W-1:0];
      REG_BLUE_GAIN:     shadow_cfg.blue_gain     = data[GAIN_W-1:0];
      REG_SCHEME_SELECT: shadow_cfg.scheme_select = data[SCHEME_W-1:0];
      REG_ROW_STRIDE:    shadow_cfg.row_stride    = data[STRIDE_W-1:0];
      REG_PIXEL_BITS:    shadow_cfg.pixel_bits    = data[BPP_W-1:0];
      REG_FRAME_BASE:    shadow_cfg.frame_base    = data[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // write every register, junk in the unused upper bits, plus one index past the list
  task automatic program_config(input logic [RANGE_W-1:0] range,
                                input logic [GAIN_W-1:0] r_gain,
                                input logic [GAIN_W-1:0] g_gain,
                                input logic [GAIN_W-1:0] b_gain,
                                input logic [SCHEME_W-1:0] scheme,
                                input logic [STRIDE_W-1:0] stride,
                                input logic [BPP_W-1:0] bpp,
                                input logic [ADDR_W-1:0] base);
    write_reg(REG_COLOR_RANGE,   32'(range)  | ($urandom() << RANGE_W));
    write_reg(REG_RED_GAIN,      32'(r_gain) | ($urandom() << GAIN_W));
    write_reg(REG_GREEN_GAIN,    32'(g_gain) | ($urandom() << GAIN_W));
    write_reg(REG_BLUE_GAIN,     32'(b_gain) | ($urandom() << GAIN_W));
    write_reg(REG_SCHEME_SELECT, 32'(scheme) | ($urandom() << SCHEME_W));
    write_reg(REG_ROW_STRIDE,    32'(stride) | ($urandom() << STRIDE_W));
    write_reg(REG_PIXEL_BITS,    32'(bpp)    | ($urandom() << BPP_W));
    write_reg(REG_FRAME_BASE,    base);
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)), $urandom());
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // let every queued pixel come back, then a short pause for the pipeline
  task automatic wait_drain();
    while (pixel_q.size() != 0 || pixel_expect_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES) @(posedge clk);
  endtask

  // input driver: holds a pending transaction until it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pixel_expect_q.push_back(predict_pixel(s_tdata));
        void'(pixel_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // keep valid and data until accepted
      end else if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pixel_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output monitor and random backpressure
  always @(posedge clk) begin : monitor
    pixel_out_t got;
    pixel_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pixel_expect_q.size() == 0) begin
          $error("output transaction with nothing expected: %h", m_tdata);
          fail_count++;
        end else begin
          want = pixel_expect_q.pop_front();
          pixels_checked++;
          if (got.address !== want.address) begin
            $error("pixel_address expected %h actual %h", want.address, got.address);
            fail_count++;
          end
          if (got.color !== want.color) begin
            $error("pixel_color expected %h actual %h", want.color, got.color);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus: directed settings first, then random settings and pixels
  initial begin : stimulus
    logic [RANGE_W-1:0]    rnd_range;
    logic [GAIN_W-1:0]     rnd_gain [3];
    logic [STRIDE_W-1:0]   rnd_stride;
    logic [BPP_W-1:0]      rnd_bpp;
    logic [ADDR_W-1:0]     rnd_base;
    logic [ITER_BITS-1:0]  rnd_iter;
    logic [COORD_BITS-1:0] rnd_x;
    logic [COORD_BITS-1:0] rnd_y;
    shadow_cfg = '{color_range: 24'd4096, red_gain: 16'd1024, green_gain: 16'd1024,
                   blue_gain: 16'd1024, scheme_select: SCHEME_RED, row_stride: 16'd4096,
                   pixel_bits: 7'd32, frame_base: 32'd0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 57;

    // reset settings: field extremes and the peaks of the three weights
    pixel_q.push_back(pack_pixel(12'd0, 12'd0, 12'd0));
    pixel_q.push_back(pack_pixel(12'hFFF, 12'hFFF, 12'hFFF));
    pixel_q.push_back(pack_pixel(12'd1024, 12'd1, 12'd2));
    pixel_q.push_back(pack_pixel(12'd2048, 12'hAAA, 12'h555));
    pixel_q.push_back(pack_pixel(12'd3072, 12'h555, 12'hAAA));
    pixel_q.push_back(pack_pixel(12'hFFF, 12'd0, 12'hFFF));
    wait_drain();

    // green scheme, full gains saturate, n reaching and passing one, narrow pixels
    program_config(24'd8192, 16'hFFFF, 16'hFFFF, 16'hFFFF, SCHEME_GREEN, 16'hFFFF,
                   7'd7, 32'hFFFF_FFFF);
    pixel_q.push_back(pack_pixel(12'd512, 12'hFFF, 12'd0));
    pixel_q.push_back(pack_pixel(12'd1024, 12'd100, 12'd200));
    pixel_q.push_back(pack_pixel(12'd1536, 12'hFFF, 12'hFFF));
    pixel_q.push_back(pack_pixel(12'd2048, 12'd7, 12'd9));
    pixel_q.push_back(pack_pixel(12'hFFF, 12'd1, 12'd1));
    wait_drain();

    // blue scheme, widest range: n just below one and clamped
    program_config(24'hFF_FFFF, 16'd0, 16'd40000, 16'd1024, SCHEME_BLUE, 16'd0,
                   7'd64, 32'd0);
    pixel_q.push_back(pack_pixel(12'd1, 12'hFFF, 12'hFFF));
    pixel_q.push_back(pack_pixel(12'd0, 12'h800, 12'h001));
    pixel_q.push_back(pack_pixel(12'd2, 12'h123, 12'h456));
    wait_drain();

    // unused scheme code falls back to red, widest pixel_bits
    program_config(24'd3000, 16'd16000, 16'd16000, 16'd16000, SCHEME_UNUSED, 16'd1,
                   7'd127, 32'h8000_0000);
    pixel_q.push_back(pack_pixel(12'd1400, 12'd3, 12'd5));
    pixel_q.push_back(pack_pixel(12'd700, 12'hFFF, 12'd0));
    pixel_q.push_back(pack_pixel(12'hFFF, 12'd0, 12'hFFF));
    wait_drain();

    // zero range keeps n at zero
    program_config(24'd0, 16'hFFFF, 16'd1024, 16'hFFFF, SCHEME_RED, 16'd640,
                   7'd8, 32'h0000_1000);
    pixel_q.push_back(pack_pixel(12'hFFF, 12'hFFF, 12'hFFF));
    pixel_q.push_back(pack_pixel(12'd1234, 12'd77, 12'd99));
    wait_drain();

    // random settings, each followed by a batch of random pixels
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < RANDOM_PHASES / 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 57;
      end else if (phase < 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // ranges near 4096 sweep n across the whole unit interval
      case ($urandom_range(0, 9))
        0:       rnd_range = '0;
        1:       rnd_range = '1;
        2:       rnd_range = RANGE_W'($urandom());
        default: rnd_range = RANGE_W'($urandom_range(1024, 16384));
      endcase
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 7))
          0:       rnd_gain[c] = '0;
          1:       rnd_gain[c] = '1;
          2, 3, 4: rnd_gain[c] = GAIN_W'($urandom_range(256, 4096));
          default: rnd_gain[c] = GAIN_W'($urandom());
        endcase
      end
      case ($urandom_range(0, 5))
        0:       rnd_stride = '0;
        1:       rnd_stride = '1;
        default: rnd_stride = STRIDE_W'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0:       rnd_bpp = BPP_W'($urandom_range(0, 7));
        1:       rnd_bpp = '1;
        2:       rnd_bpp = 7'd64;
        default: rnd_bpp = BPP_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 5))
        0:       rnd_base = '0;
        1:       rnd_base = '1;
        default: rnd_base = $urandom();
      endcase
      program_config(rnd_range, rnd_gain[0], rnd_gain[1], rnd_gain[2],
                     SCHEME_W'($urandom_range(0, 3)), rnd_stride, rnd_bpp, rnd_base);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        case ($urandom_range(0, 9))
          0:       rnd_iter = '0;
          1:       rnd_iter = '1;
          default: rnd_iter = ITER_BITS'($urandom());
        endcase
        rnd_x = ($urandom_range(0, 9) == 0) ? '1 : COORD_BITS'($urandom());
        rnd_y = ($urandom_range(0, 9) == 0) ? '0 : COORD_BITS'($urandom());
        pixel_q.push_back(pack_pixel(rnd_iter, rnd_x, rnd_y));
      end
      wait_drain();
    end

    // final drain and verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_expect_q.size() != 0) begin
      $error("%0d expected pixels never came back", pixel_expect_q.size());
      fail_count++;
    end
    $display("checked %0d pixels under %0d register settings (%0d register writes)",
             pixels_checked, settings_run, reg_writes);
    $display("covered all schemes, clamp of n, gain saturation and narrow pixel sizes");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
